/* rtl/circular_list_with_cursor_top_assert.svh */
// Assertion macros shared by the RTL of the circular list block.
`ifndef CIRCULAR_LIST_WITH_CURSOR_TOP_ASSERT_SVH
`define CIRCULAR_LIST_WITH_CURSOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("circular list assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circular list assertion failed");

`endif

/* rtl/cllc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cllc_pkg;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned ITEM_W     = 32;
  localparam int unsigned SIZE_W     = 7;
  localparam int unsigned DEPTH_DEF  = 64;
  localparam int unsigned DATA_W_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_ADVANCE = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_INS,
    ST_INS_LINK,
    ST_RM,
    ST_ADV,
    ST_FRONT,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* rtl/cllc_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cllc_in_if;
  import cllc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ITEM_W-1:0] item;

  modport source (output valid, cmd, item, input ready);
  modport sink   (input valid, cmd, item, output ready);

endinterface

`default_nettype wire

/* rtl/cllc_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cllc_out_if;
  import cllc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ITEM_W-1:0] back_item;
  logic [ITEM_W-1:0] front_item;
  logic [SIZE_W-1:0] size;
  logic              is_empty;
  logic              error;

  modport source (output valid, back_item, front_item, size, is_empty, error, input ready);
  modport sink   (input valid, back_item, front_item, size, is_empty, error, output ready);

endinterface

`default_nettype wire

/* rtl/cllc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module cllc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/circular_list_with_cursor_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bounded circular list with a cursor. Each input transaction carries a command (insert after
// the cursor, remove the node after the cursor, advance, query, clear) and yields exactly one
// result transaction with the cursor value, the value after it, the size, an empty flag and an
// error flag. Nodes live in one memory holding {value, next link} per slot, freed slots in a
// second memory used as a stack; cursor, next link and both reported values are mirrored in
// registers. Query, clear, refused commands and removal of the last node go straight to the
// result state; an insert first pops the free stack when it reuses a freed slot, then writes the
// new node and, in a non-empty list, relinks the cursor node through the single write port of the
// node memory; remove and advance read the next node, then the node after it. A stalled output
// holds the result state. A new command is accepted while the previous result still waits.

module circular_list_with_cursor_top #(
  parameter int unsigned DEPTH  = cllc_pkg::DEPTH_DEF,
  parameter int unsigned DATA_W = cllc_pkg::DATA_W_DEF
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  cllc_in_if.sink    in_i,
  cllc_out_if.source out_o
);
  import cllc_pkg::*;

`include "circular_list_with_cursor_top_assert.svh"

  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned NODE_W = DATA_W + AW;

  state_e            state_q, state_d;
  logic [AW-1:0]     cursor_q, cursor_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     free_top_q, free_top_d;
  logic [CW-1:0]     fresh_q, fresh_d;
  logic              out_valid_q, out_valid_d;

  logic [DATA_W-1:0] item_q, item_d;
  logic              err_q, err_d;
  logic [AW-1:0]     slot_q, slot_d;
  logic [AW-1:0]     next_q, next_d;
  logic [DATA_W-1:0] back_q, back_d;
  logic [DATA_W-1:0] front_q, front_d;
  logic [ITEM_W-1:0] out_back_q, out_back_d;
  logic [ITEM_W-1:0] out_front_q, out_front_d;
  logic [SIZE_W-1:0] out_size_q, out_size_d;
  logic              out_empty_q, out_empty_d;
  logic              out_err_q, out_err_d;

  logic              node_we, node_re;
  logic [AW-1:0]     node_waddr, node_raddr;
  logic [NODE_W-1:0] node_wdata, node_rdata;
  logic [DATA_W-1:0] node_rd_val;
  logic [AW-1:0]     node_rd_link;

  logic              free_we, free_re;
  logic [AW-1:0]     free_waddr, free_raddr;
  logic [AW-1:0]     free_wdata, free_rdata;
  logic [CW-1:0]     free_dec;
  logic              fresh_sat;
  logic              stack_full;
  logic              list_full;
  logic              list_empty;

  assign node_rd_val  = node_rdata[AW +: DATA_W];
  assign node_rd_link = node_rdata[AW-1:0];
  assign free_dec     = free_top_q - 1'b1;
  assign fresh_sat    = (fresh_q == CW'(DEPTH));
  assign stack_full   = (free_top_q == CW'(DEPTH));
  assign list_full    = (count_q == CW'(DEPTH));
  assign list_empty   = (count_q == '0);

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.back_item  = out_back_q;
  assign out_o.front_item = out_front_q;
  assign out_o.size       = out_size_q;
  assign out_o.is_empty   = out_empty_q;
  assign out_o.error      = out_err_q;

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    count_d     = count_q;
    free_top_d  = free_top_q;
    fresh_d     = fresh_q;
    item_d      = item_q;
    err_d       = err_q;
    slot_d      = slot_q;
    next_d      = next_q;
    back_d      = back_q;
    front_d     = front_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_back_d  = out_back_q;
    out_front_d = out_front_q;
    out_size_d  = out_size_q;
    out_empty_d = out_empty_q;
    out_err_d   = out_err_q;
    node_we     = 1'b0;
    node_waddr  = '0;
    node_wdata  = '0;
    node_re     = 1'b0;
    node_raddr  = '0;
    free_we     = 1'b0;
    free_waddr  = '0;
    free_wdata  = '0;
    free_re     = 1'b0;
    free_raddr  = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          item_d  = DATA_W'(in_i.item);
          err_d   = 1'b0;
          state_d = ST_DONE;
          case (in_i.cmd)
            CMD_INSERT: begin
              if (list_full) begin
                err_d = 1'b1;
              end else if (free_top_q != '0) begin
                free_re    = 1'b1;
                free_raddr = free_dec[AW-1:0];
                free_top_d = free_dec;
                state_d    = ST_POP;
              end else begin
                slot_d = fresh_sat ? '0 : fresh_q[AW-1:0];
                if (!fresh_sat) begin
                  fresh_d = fresh_q + 1'b1;
                end
                state_d = ST_INS;
              end
            end
            CMD_REMOVE: begin
              if (list_empty) begin
                err_d = 1'b1;
              end else if (count_q == CW'(1)) begin
                // The cursor node is the only one, so it goes itself.
                if (!stack_full) begin
                  free_we    = 1'b1;
                  free_waddr = free_top_q[AW-1:0];
                  free_wdata = cursor_q;
                  free_top_d = free_top_q + 1'b1;
                end
                count_d = '0;
              end else begin
                node_re    = 1'b1;
                node_raddr = next_q;
                state_d    = ST_RM;
              end
            end
            CMD_ADVANCE: begin
              if (list_empty) begin
                err_d = 1'b1;
              end else begin
                node_re    = 1'b1;
                node_raddr = next_q;
                cursor_d   = next_q;
                back_d     = front_q;
                state_d    = ST_ADV;
              end
            end
            CMD_CLEAR: begin
              count_d    = '0;
              free_top_d = '0;
              fresh_d    = '0;
            end
            CMD_QUERY: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        slot_d  = free_rdata;
        state_d = ST_INS;
      end
      ST_INS: begin
        node_we    = 1'b1;
        node_waddr = slot_q;
        if (list_empty) begin
          // First node links to itself and becomes the cursor.
          node_wdata = {item_q, slot_q};
          cursor_d   = slot_q;
          next_d     = slot_q;
          back_d     = item_q;
          front_d    = item_q;
          count_d    = count_q + 1'b1;
          state_d    = ST_DONE;
        end else begin
          node_wdata = {item_q, next_q};
          state_d    = ST_INS_LINK;
        end
      end
      ST_INS_LINK: begin
        node_we    = 1'b1;
        node_waddr = cursor_q;
        node_wdata = {back_q, slot_q};
        next_d     = slot_q;
        front_d    = item_q;
        count_d    = count_q + 1'b1;
        state_d    = ST_DONE;
      end
      ST_RM: begin
        node_we    = 1'b1;
        node_waddr = cursor_q;
        node_wdata = {back_q, node_rd_link};
        if (!stack_full) begin
          free_we    = 1'b1;
          free_waddr = free_top_q[AW-1:0];
          free_wdata = next_q;
          free_top_d = free_top_q + 1'b1;
        end
        count_d    = count_q - 1'b1;
        next_d     = node_rd_link;
        node_re    = 1'b1;
        node_raddr = node_rd_link;
        state_d    = ST_FRONT;
      end
      ST_ADV: begin
        next_d     = node_rd_link;
        node_re    = 1'b1;
        node_raddr = node_rd_link;
        state_d    = ST_FRONT;
      end
      ST_FRONT: begin
        // A ring of one reads its own value; take it from the cursor register since the
        // cursor node may have been rewritten in the same cycle as the read.
        front_d = (next_q == cursor_q) ? back_q : node_rd_val;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_back_d  = list_empty ? '0 : ITEM_W'(back_q);
          out_front_d = list_empty ? '0 : ITEM_W'(front_q);
          out_size_d  = SIZE_W'(count_q);
          out_empty_d = list_empty;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      count_q     <= '0;
      free_top_q  <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      count_q     <= count_d;
      free_top_q  <= free_top_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    err_q       <= err_d;
    slot_q      <= slot_d;
    next_q      <= next_d;
    back_q      <= back_d;
    front_q     <= front_d;
    out_back_q  <= out_back_d;
    out_front_q <= out_front_d;
    out_size_q  <= out_size_d;
    out_empty_q <= out_empty_d;
    out_err_q   <= out_err_d;
  end

  cllc_ram #(
    .WIDTH (NODE_W),
    .DEPTH (DEPTH)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  cllc_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (free_waddr),
    .wdata_i (free_wdata),
    .re_i    (free_re),
    .raddr_i (free_raddr),
    .rdata_o (free_rdata)
  );

  // Every slot ever handed out is either in the ring or on the free stack.
  `CLLC_ASSERT_IMP(a_slot_balance, clk_i, rst_ni, state_q == ST_IDLE, ({1'b0, count_q} + {1'b0, free_top_q}) == {1'b0, fresh_q})

  `CLLC_ASSERT_IMP(a_single_self_link, clk_i, rst_ni, (state_q == ST_IDLE) && (count_q == CW'(1)), next_q == cursor_q)

  `CLLC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, state_q != ST_IDLE)

  `CLLC_ASSERT_IMP(a_result_empty_flag, clk_i, rst_ni, out_valid_q, out_empty_q == (out_size_q == '0))

endmodule

`default_nettype wire
